### rtl/npe_pkg.sv
// Shared constants and types of the nearest-point polygon editor.
`timescale 1ns / 1ps

package npe_pkg;

  localparam int MAX_POINTS = 64;
  localparam int COORD_BITS = 10;
  localparam int MIN_POLY   = 3;

  localparam int IDX_W    = $clog2(MAX_POINTS);
  localparam int CNT_W    = $clog2(MAX_POINTS + 1);
  localparam int WORD_W   = 2 * COORD_BITS;
  localparam int DIST_W   = 2 * COORD_BITS + 1;
  localparam int ACT_W    = 3;
  localparam int ENTRY_W  = 6;
  localparam int STAT_W   = 2;

  typedef enum logic [ACT_W-1:0] {
    ACT_ADD    = 3'd0,
    ACT_REMOVE = 3'd1,
    ACT_MOVE   = 3'd2,
    ACT_CLEAR  = 3'd3,
    ACT_READ   = 3'd4
  } npe_action_e;

  typedef enum logic [STAT_W-1:0] {
    STAT_DONE  = 2'd0,
    STAT_EMPTY = 2'd1,
    STAT_FULL  = 2'd2,
    STAT_RANGE = 2'd3
  } npe_status_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_NBR,
    ST_SHIFT_UP,
    ST_SHIFT_DN,
    ST_READ,
    ST_DONE
  } npe_state_e;

  typedef struct packed {
    logic              valid;
    logic [IDX_W-1:0]  idx;
    logic [DIST_W-1:0] dist_sq;
  } npe_dist_t;

endpackage

### rtl/npe_if.sv
// Valid/ready channel interfaces for the editor's requests and responses.
`timescale 1ns / 1ps

interface npe_in_if;
  logic                         valid;
  logic                         ready;
  logic [npe_pkg::ACT_W-1:0]      action;
  logic [npe_pkg::COORD_BITS-1:0] x_coord;
  logic [npe_pkg::COORD_BITS-1:0] y_coord;
  logic [npe_pkg::ENTRY_W-1:0]    entry_index;

  modport source (output valid, action, x_coord, y_coord, entry_index, input ready);
  modport sink   (input valid, action, x_coord, y_coord, entry_index, output ready);
endinterface

interface npe_out_if;
  logic                           valid;
  logic                           ready;
  logic [npe_pkg::STAT_W-1:0]     status;
  logic [npe_pkg::IDX_W-1:0]      affected_index;
  logic [npe_pkg::CNT_W-1:0]      point_count;
  logic [npe_pkg::COORD_BITS-1:0] x_out;
  logic [npe_pkg::COORD_BITS-1:0] y_out;

  modport source (output valid, status, affected_index, point_count, x_out, y_out,
                  input ready);
  modport sink   (input valid, status, affected_index, point_count, x_out, y_out,
                  output ready);
endinterface

### rtl/nearest_point_polygon_editor.sv
// Nearest-point polygon editor: the vertex list in one RAM, edited by a sequencer.
`timescale 1ns / 1ps

// The block holds a circular list of up to MAX_POINTS vertices in a single
// RAM with one read and one write port, and handles one request at a time.
// Clear, refused requests, unused action codes, reads and adds to a list of
// fewer than three vertices need no scan. Remove, move and the general add
// first scan all n stored vertices through the distance stage; add then
// fetches both neighbours and shifts the entries from the insertion point up
// by one, remove shifts the entries above the deleted vertex down, one entry
// per cycle. A response may wait in the output register while the next
// request is already accepted.
module nearest_point_polygon_editor (
  input  logic      clk_i,
  input  logic      rst_ni,
  npe_in_if.sink    in_i,
  npe_out_if.source out_o
);
  import npe_pkg::*;

  npe_state_e state_q, state_d;

  logic [CNT_W-1:0]      count_q, count_d;
  logic [ACT_W-1:0]      act_q, act_d;
  logic [COORD_BITS-1:0] x_q, x_d, y_q, y_d;
  logic [CNT_W-1:0]      ctr_q, ctr_d;
  logic                  s1_v_q, s1_v_d, s1_wr_q, s1_wr_d;
  logic [IDX_W-1:0]      s1_addr_q, s1_addr_d;
  logic [DIST_W-1:0]     best_q, best_d, dn_q, dn_d;
  logic [IDX_W-1:0]      best_idx_q, best_idx_d;
  logic                  nbr_got_q, nbr_got_d;
  logic [CNT_W-1:0]      pos_q, pos_d;
  npe_status_e           res_status_q, res_status_d;
  logic [IDX_W-1:0]      res_aff_q, res_aff_d;
  logic [COORD_BITS-1:0] res_x_q, res_x_d, res_y_q, res_y_d;

  logic                  out_valid_q, out_valid_d;
  npe_status_e           out_status_q, out_status_d;
  logic [IDX_W-1:0]      out_aff_q, out_aff_d;
  logic [CNT_W-1:0]      out_cnt_q, out_cnt_d;
  logic [COORD_BITS-1:0] out_x_q, out_x_d, out_y_q, out_y_d;

  logic              accept, scan_done, out_free;
  logic              rd_en, wr_en;
  logic [IDX_W-1:0]  rd_addr, wr_addr, nx_idx, pv_idx;
  logic [WORD_W-1:0] wr_data, rd_data;
  logic [CNT_W-1:0]  best_ext, new_pos;
  npe_dist_t         dist_s;

  npe_ram #(
    .WIDTH (WORD_W),
    .DEPTH (MAX_POINTS)
  ) u_store (
    .clk_i     (clk_i),
    .wr_en_i   (wr_en),
    .wr_addr_i (wr_addr),
    .wr_data_i (wr_data),
    .rd_en_i   (rd_en),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_data)
  );

  npe_dist u_dist (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (s1_v_q),
    .idx_i   (s1_addr_q),
    .word_i  (rd_data),
    .x_i     (x_q),
    .y_i     (y_q),
    .dist_o  (dist_s)
  );

  assign in_i.ready = (state_q == ST_IDLE);
  assign accept     = in_i.valid & in_i.ready;
  assign out_free   = !out_valid_q || out_o.ready;

  // The scan is over once every vertex was issued and the pipeline has drained.
  assign scan_done = (ctr_q == count_q) && !s1_v_q && !dist_s.valid;

  assign best_ext = CNT_W'(best_idx_q);
  assign nx_idx   = (best_ext + CNT_W'(1) == count_q) ? '0 : IDX_W'(best_ext + CNT_W'(1));
  assign pv_idx   = (best_idx_q == '0) ? IDX_W'(count_q - CNT_W'(1)) : best_idx_q - IDX_W'(1);
  assign new_pos  = (dn_q < dist_s.dist_sq) ? best_ext + CNT_W'(1) : best_ext;

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          case (in_i.action)
            ACT_ADD: begin
              if (count_q >= CNT_W'(MAX_POINTS) || count_q < CNT_W'(MIN_POLY)) begin
                state_d = ST_DONE;
              end else begin
                state_d = ST_SCAN;
              end
            end
            ACT_REMOVE, ACT_MOVE: begin
              state_d = (count_q == '0) ? ST_DONE : ST_SCAN;
            end
            ACT_READ: begin
              if (count_q == '0 || CNT_W'(in_i.entry_index) >= count_q) begin
                state_d = ST_DONE;
              end else begin
                state_d = ST_READ;
              end
            end
            default: state_d = ST_DONE;
          endcase
        end
      end
      ST_SCAN: begin
        if (scan_done) begin
          case (act_q)
            ACT_ADD:    state_d = ST_NBR;
            ACT_REMOVE: state_d = ST_SHIFT_DN;
            default:    state_d = ST_DONE;
          endcase
        end
      end
      ST_NBR: begin
        if (dist_s.valid && nbr_got_q) begin
          state_d = ST_SHIFT_UP;
        end
      end
      ST_SHIFT_UP: begin
        if (ctr_q == pos_q && !s1_wr_q) begin
          state_d = ST_DONE;
        end
      end
      ST_SHIFT_DN: begin
        if (ctr_q == count_q && !s1_wr_q) begin
          state_d = ST_DONE;
        end
      end
      ST_READ: state_d = ST_DONE;
      ST_DONE: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Datapath control, memory ports and result.
  always_comb begin
    count_d      = count_q;
    act_d        = act_q;
    x_d          = x_q;
    y_d          = y_q;
    ctr_d        = ctr_q;
    s1_v_d       = 1'b0;
    s1_wr_d      = 1'b0;
    s1_addr_d    = s1_addr_q;
    best_d       = best_q;
    best_idx_d   = best_idx_q;
    dn_d         = dn_q;
    nbr_got_d    = nbr_got_q;
    pos_d        = pos_q;
    res_status_d = res_status_q;
    res_aff_d    = res_aff_q;
    res_x_d      = res_x_q;
    res_y_d      = res_y_q;
    rd_en        = 1'b0;
    rd_addr      = '0;
    wr_en        = 1'b0;
    wr_addr      = '0;
    wr_data      = {y_q, x_q};

    out_valid_d  = out_valid_q && !out_o.ready;
    out_status_d = out_status_q;
    out_aff_d    = out_aff_q;
    out_cnt_d    = out_cnt_q;
    out_x_d      = out_x_q;
    out_y_d      = out_y_q;

    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          act_d        = in_i.action;
          x_d          = in_i.x_coord;
          y_d          = in_i.y_coord;
          ctr_d        = '0;
          res_status_d = STAT_DONE;
          res_aff_d    = '0;
          res_x_d      = '0;
          res_y_d      = '0;
          case (in_i.action)
            ACT_ADD: begin
              if (count_q >= CNT_W'(MAX_POINTS)) begin
                res_status_d = STAT_FULL;
              end else if (count_q < CNT_W'(MIN_POLY)) begin
                wr_en     = 1'b1;
                wr_addr   = IDX_W'(count_q);
                wr_data   = {in_i.y_coord, in_i.x_coord};
                res_aff_d = IDX_W'(count_q);
                count_d   = count_q + CNT_W'(1);
              end
            end
            ACT_REMOVE, ACT_MOVE: begin
              if (count_q == '0) begin
                res_status_d = STAT_EMPTY;
              end
            end
            ACT_CLEAR: count_d = '0;
            ACT_READ: begin
              if (count_q == '0) begin
                res_status_d = STAT_EMPTY;
              end else if (CNT_W'(in_i.entry_index) >= count_q) begin
                res_status_d = STAT_RANGE;
              end else begin
                rd_en     = 1'b1;
                rd_addr   = IDX_W'(in_i.entry_index);
                res_aff_d = IDX_W'(in_i.entry_index);
              end
            end
            default: ;
          endcase
        end
      end
      ST_SCAN: begin
        if (ctr_q < count_q) begin
          rd_en     = 1'b1;
          rd_addr   = IDX_W'(ctr_q);
          s1_v_d    = 1'b1;
          s1_addr_d = IDX_W'(ctr_q);
          ctr_d     = ctr_q + CNT_W'(1);
        end
        // Vertex 0 seeds the minimum; later ones replace it only when strictly nearer.
        if (dist_s.valid && (dist_s.idx == '0 || dist_s.dist_sq < best_q)) begin
          best_d     = dist_s.dist_sq;
          best_idx_d = dist_s.idx;
        end
        if (scan_done) begin
          res_aff_d = best_idx_q;
          case (act_q)
            ACT_ADD: begin
              ctr_d     = '0;
              nbr_got_d = 1'b0;
            end
            ACT_REMOVE: ctr_d = best_ext + CNT_W'(1);
            default: begin
              wr_en   = 1'b1;
              wr_addr = best_idx_q;
            end
          endcase
        end
      end
      ST_NBR: begin
        if (ctr_q == '0) begin
          rd_en     = 1'b1;
          rd_addr   = nx_idx;
          s1_v_d    = 1'b1;
          s1_addr_d = nx_idx;
          ctr_d     = CNT_W'(1);
        end else if (ctr_q == CNT_W'(1)) begin
          rd_en     = 1'b1;
          rd_addr   = pv_idx;
          s1_v_d    = 1'b1;
          s1_addr_d = pv_idx;
          ctr_d     = CNT_W'(2);
        end
        // The next neighbour's distance arrives first, the previous one's second.
        if (dist_s.valid) begin
          if (!nbr_got_q) begin
            dn_d      = dist_s.dist_sq;
            nbr_got_d = 1'b1;
          end else begin
            pos_d     = new_pos;
            res_aff_d = IDX_W'(new_pos);
            ctr_d     = count_q;
          end
        end
      end
      ST_SHIFT_UP: begin
        if (s1_wr_q) begin
          wr_en   = 1'b1;
          wr_addr = s1_addr_q;
          wr_data = rd_data;
        end
        if (ctr_q > pos_q) begin
          rd_en     = 1'b1;
          rd_addr   = IDX_W'(ctr_q - CNT_W'(1));
          s1_wr_d   = 1'b1;
          s1_addr_d = IDX_W'(ctr_q);
          ctr_d     = ctr_q - CNT_W'(1);
        end else if (!s1_wr_q) begin
          wr_en   = 1'b1;
          wr_addr = IDX_W'(pos_q);
          count_d = count_q + CNT_W'(1);
        end
      end
      ST_SHIFT_DN: begin
        if (s1_wr_q) begin
          wr_en   = 1'b1;
          wr_addr = s1_addr_q;
          wr_data = rd_data;
        end
        if (ctr_q < count_q) begin
          rd_en     = 1'b1;
          rd_addr   = IDX_W'(ctr_q);
          s1_wr_d   = 1'b1;
          s1_addr_d = IDX_W'(ctr_q - CNT_W'(1));
          ctr_d     = ctr_q + CNT_W'(1);
        end else if (!s1_wr_q) begin
          count_d = count_q - CNT_W'(1);
        end
      end
      ST_READ: begin
        res_x_d = rd_data[COORD_BITS-1:0];
        res_y_d = rd_data[WORD_W-1:COORD_BITS];
      end
      ST_DONE: begin
        if (out_free) begin
          out_valid_d  = 1'b1;
          out_status_d = res_status_q;
          out_aff_d    = res_aff_q;
          out_cnt_d    = count_q;
          out_x_d      = res_x_q;
          out_y_d      = res_y_q;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      count_q     <= '0;
      ctr_q       <= '0;
      s1_v_q      <= 1'b0;
      s1_wr_q     <= 1'b0;
      nbr_got_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      ctr_q       <= ctr_d;
      s1_v_q      <= s1_v_d;
      s1_wr_q     <= s1_wr_d;
      nbr_got_q   <= nbr_got_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    act_q        <= act_d;
    x_q          <= x_d;
    y_q          <= y_d;
    s1_addr_q    <= s1_addr_d;
    best_q       <= best_d;
    best_idx_q   <= best_idx_d;
    dn_q         <= dn_d;
    pos_q        <= pos_d;
    res_status_q <= res_status_d;
    res_aff_q    <= res_aff_d;
    res_x_q      <= res_x_d;
    res_y_q      <= res_y_d;
    out_status_q <= out_status_d;
    out_aff_q    <= out_aff_d;
    out_cnt_q    <= out_cnt_d;
    out_x_q      <= out_x_d;
    out_y_q      <= out_y_d;
  end

  assign out_o.valid          = out_valid_q;
  assign out_o.status         = out_status_q;
  assign out_o.affected_index = out_aff_q;
  assign out_o.point_count    = out_cnt_q;
  assign out_o.x_out          = out_x_q;
  assign out_o.y_out          = out_y_q;

endmodule

### rtl/npe_ram.sv
// Generic single-write, single-read RAM with a registered read port.
`timescale 1ns / 1ps

module npe_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     wr_en_i,
  input  logic [$clog2(DEPTH)-1:0] wr_addr_i,
  input  logic [WIDTH-1:0]         wr_data_i,
  input  logic                     rd_en_i,
  input  logic [$clog2(DEPTH)-1:0] rd_addr_i,
  output logic [WIDTH-1:0]         rd_data_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_data_o <= mem_q[rd_addr_i];
    end
  end

endmodule

### rtl/npe_dist.sv
// Squared-distance stage: one stored vertex against the request point, registered.
`timescale 1ns / 1ps

module npe_dist (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              valid_i,
  input  logic [npe_pkg::IDX_W-1:0]         idx_i,
  input  logic [npe_pkg::WORD_W-1:0]        word_i,
  input  logic [npe_pkg::COORD_BITS-1:0]    x_i,
  input  logic [npe_pkg::COORD_BITS-1:0]    y_i,
  output npe_pkg::npe_dist_t                dist_o
);
  import npe_pkg::*;

  logic [COORD_BITS-1:0]   px, py, dx, dy;
  logic [2*COORD_BITS-1:0] dx2, dy2;
  logic [DIST_W-1:0]       sum;
  logic                    valid_q;
  logic [IDX_W-1:0]        idx_q;
  logic [DIST_W-1:0]       dist_q;

  always_comb begin
    px  = word_i[COORD_BITS-1:0];
    py  = word_i[WORD_W-1:COORD_BITS];
    dx  = (px > x_i) ? (px - x_i) : (x_i - px);
    dy  = (py > y_i) ? (py - y_i) : (y_i - py);
    dx2 = dx * dx;
    dy2 = dy * dy;
    sum = DIST_W'(dx2) + DIST_W'(dy2);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q  <= idx_i;
    dist_q <= sum;
  end

  assign dist_o = '{valid: valid_q, idx: idx_q, dist_sq: dist_q};

endmodule

### rtl/npe_checker.sv
// Port-level checks of the polygon editor and their binding to the top level.
`timescale 1ns / 1ps

module npe_checker (
  input logic                           clk_i,
  input logic                           rst_ni,
  input logic                           out_valid_i,
  input logic                           out_ready_i,
  input logic [npe_pkg::STAT_W-1:0]     out_status_i,
  input logic [npe_pkg::CNT_W-1:0]      out_count_i,
  input logic [npe_pkg::COORD_BITS-1:0] out_x_i
);
  import npe_pkg::*;

  // A response that is not taken stays offered.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("response withdrawn while stalled");

  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> out_count_i <= CNT_W'(MAX_POINTS))
    else $error("vertex count beyond capacity");

  a_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_status_i == STAT_FULL |-> out_count_i == CNT_W'(MAX_POINTS))
    else $error("full status with room left");

  a_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_status_i == STAT_EMPTY |-> out_count_i == '0 && out_x_i == '0)
    else $error("empty status on a non-empty list");

  a_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_status_i == STAT_RANGE |-> out_count_i != '0 && out_x_i == '0)
    else $error("range status on an empty list");

endmodule

bind nearest_point_polygon_editor npe_checker u_npe_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .out_valid_i  (out_o.valid),
  .out_ready_i  (out_o.ready),
  .out_status_i (out_o.status),
  .out_count_i  (out_o.point_count),
  .out_x_i      (out_o.x_out)
);

### tb/testbench.sv
// Self-checking testbench for the nearest-point polygon editor.
`timescale 1ns / 1ps

module testbench;
  import npe_pkg::*;

  typedef struct {
    npe_status_e            status;
    logic [IDX_W-1:0]       affected;
    logic [CNT_W-1:0]       count;
    logic [COORD_BITS-1:0]  x;
    logic [COORD_BITS-1:0]  y;
  } edit_result_t;

  logic clk;
  logic rst_n;

  npe_in_if  req_bus ();
  npe_out_if rsp_bus ();

  nearest_point_polygon_editor u_top (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .in_i   (req_bus),
    .out_o  (rsp_bus)
  );

  // Predicted polygon, updated as each request beat is accepted.
  logic [COORD_BITS-1:0] poly_x [MAX_POINTS];
  logic [COORD_BITS-1:0] poly_y [MAX_POINTS];
  int                    poly_count = 0;

  edit_result_t expected_results [$];
  int           failures   = 0;
  int           stall_left = 0;
  bit           idle_on    = 1'b1;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #10_000_000;
    $display("Some tests failed");
    $finish;
  end

  function automatic int unsigned sq_dist(int i, logic [COORD_BITS-1:0] px,
                                          logic [COORD_BITS-1:0] py);
    int unsigned dx;
    int unsigned dy;
    dx = (poly_x[i] > px) ? poly_x[i] - px : px - poly_x[i];
    dy = (poly_y[i] > py) ? poly_y[i] - py : py - poly_y[i];
    return dx * dx + dy * dy;
  endfunction

  // The first vertex at the minimum distance wins.
  function automatic int closest_vertex(logic [COORD_BITS-1:0] px,
                                        logic [COORD_BITS-1:0] py);
    int          best;
    int unsigned best_d;
    int unsigned d;
    best   = 0;
    best_d = sq_dist(0, px, py);
    for (int i = 1; i < poly_count; i++) begin
      d = sq_dist(i, px, py);
      if (d < best_d) begin
        best_d = d;
        best   = i;
      end
    end
    return best;
  endfunction

  function automatic void apply_edit(logic [ACT_W-1:0] action, logic [COORD_BITS-1:0] px,
                                     logic [COORD_BITS-1:0] py, logic [ENTRY_W-1:0] idx);
    edit_result_t res;
    int           n;
    int           nxt;
    int           prv;
    int           pos;
    res = '{STAT_DONE, '0, '0, '0, '0};
    case (action)
      ACT_ADD: begin
        if (poly_count >= MAX_POINTS) begin
          res.status = STAT_FULL;
        end else begin
          if (poly_count < MIN_POLY) begin
            pos = poly_count;
          end else begin
            n   = closest_vertex(px, py);
            nxt = (n + 1 == poly_count) ? 0 : n + 1;
            prv = (n == 0) ? poly_count - 1 : n - 1;
            pos = (sq_dist(nxt, px, py) < sq_dist(prv, px, py)) ? n + 1 : n;
          end
          for (int i = poly_count; i > pos; i--) begin
            poly_x[i] = poly_x[i-1];
            poly_y[i] = poly_y[i-1];
          end
          poly_x[pos] = px;
          poly_y[pos] = py;
          poly_count++;
          res.affected = IDX_W'(pos);
        end
      end
      ACT_REMOVE: begin
        if (poly_count == 0) begin
          res.status = STAT_EMPTY;
        end else begin
          n = closest_vertex(px, py);
          for (int i = n; i + 1 < poly_count; i++) begin
            poly_x[i] = poly_x[i+1];
            poly_y[i] = poly_y[i+1];
          end
          poly_count--;
          res.affected = IDX_W'(n);
        end
      end
      ACT_MOVE: begin
        if (poly_count == 0) begin
          res.status = STAT_EMPTY;
        end else begin
          n = closest_vertex(px, py);
          poly_x[n] = px;
          poly_y[n] = py;
          res.affected = IDX_W'(n);
        end
      end
      ACT_CLEAR: poly_count = 0;
      ACT_READ: begin
        if (poly_count == 0) begin
          res.status = STAT_EMPTY;
        end else if (idx >= poly_count) begin
          res.status = STAT_RANGE;
        end else begin
          res.affected = idx;
          res.x        = poly_x[idx];
          res.y        = poly_y[idx];
        end
      end
      default: ;
    endcase
    res.count = CNT_W'(poly_count);
    expected_results.push_back(res);
  endfunction

  // Drives one request beat; valid stays high between back-to-back beats.
  task automatic send_edit(logic [ACT_W-1:0] action, logic [COORD_BITS-1:0] px,
                           logic [COORD_BITS-1:0] py, logic [ENTRY_W-1:0] idx);
    int gap;
    gap = idle_on ? $urandom_range(0, 11) : 0;
    @(negedge clk);
    if (gap != 0) begin
      req_bus.valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    req_bus.valid       = 1'b1;
    req_bus.action      = action;
    req_bus.x_coord     = px;
    req_bus.y_coord     = py;
    req_bus.entry_index = idx;
    do @(posedge clk); while (!req_bus.ready);
    apply_edit(action, px, py, idx);
  endtask

  task automatic wait_drained();
    @(negedge clk);
    req_bus.valid = 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
  endtask

  // Grid and corner values make distance ties common.
  function automatic logic [COORD_BITS-1:0] rand_coord();
    case ($urandom_range(0, 3))
      0:       return COORD_BITS'($urandom_range(0, 1023));
      1:       return COORD_BITS'($urandom_range(0, 7) << 7);
      2:       return $urandom_range(0, 1) ? 10'd1023 : 10'd0;
      default: return COORD_BITS'($urandom_range(0, 15));
    endcase
  endfunction

  task automatic test_directed();
    send_edit(ACT_READ, 0, 0, 0);
    send_edit(ACT_REMOVE, 5, 5, 0);
    send_edit(ACT_MOVE, 1023, 1023, 63);
    send_edit(ACT_ADD, 0, 0, 0);
    send_edit(ACT_ADD, 1023, 1023, 0);
    send_edit(ACT_ADD, 1023, 0, 0);
    send_edit(ACT_ADD, 0, 1023, 0);
    // Centre of the square: both neighbours of the nearest vertex are equally far.
    send_edit(ACT_ADD, 512, 512, 0);
    send_edit(ACT_READ, 0, 0, 0);
    send_edit(ACT_READ, 0, 0, 4);
    send_edit(ACT_READ, 0, 0, 5);
    send_edit(ACT_READ, 1023, 1023, 63);
    send_edit(ACT_MOVE, 1020, 1020, 0);
    send_edit(ACT_REMOVE, 0, 0, 0);
    send_edit(3'd5, 1023, 1023, 63);
    send_edit(3'd6, 0, 0, 0);
    send_edit(3'd7, 512, 511, 42);
    send_edit(ACT_CLEAR, 0, 0, 0);
    send_edit(ACT_READ, 0, 0, 0);
    // The next neighbour of the last vertex is nearer, so the point lands at the end.
    send_edit(ACT_ADD, 0, 0, 0);
    send_edit(ACT_ADD, 100, 0, 0);
    send_edit(ACT_ADD, 100, 100, 0);
    send_edit(ACT_ADD, 10, 110, 0);
    send_edit(ACT_READ, 0, 0, 3);
  endtask

  task automatic test_fill_to_full();
    idle_on = 1'b0;
    send_edit(ACT_CLEAR, 0, 0, 0);
    for (int i = 0; i < MAX_POINTS + 2; i++)
      send_edit(ACT_ADD, rand_coord(), rand_coord(), ENTRY_W'($urandom_range(0, 63)));
    idle_on = 1'b1;
    for (int i = 0; i < MAX_POINTS; i++)
      send_edit(ACT_READ, COORD_BITS'($urandom_range(0, 1023)),
                COORD_BITS'($urandom_range(0, 1023)), ENTRY_W'(i));
    wait_drained();
  endtask

  task automatic test_random_mix(int n_items);
    int               add_w;
    int               r;
    int               v;
    logic [ACT_W-1:0] action;
    logic [COORD_BITS-1:0] px;
    logic [COORD_BITS-1:0] py;
    logic [ENTRY_W-1:0]    idx;
    add_w = 40;
    for (int k = 0; k < n_items; k++) begin
      if (k % 100 == 0) begin
        add_w   = $urandom_range(20, 50);
        idle_on = ($urandom_range(0, 3) != 0);
      end
      r = $urandom_range(0, 99);
      if (r < add_w)          action = ACT_ADD;
      else if (r < 60)        action = ACT_REMOVE;
      else if (r < 75)        action = ACT_MOVE;
      else if (r < 95)        action = ACT_READ;
      else if (r < 96)        action = ACT_CLEAR;
      else                    action = ACT_W'($urandom_range(5, 7));
      px  = rand_coord();
      py  = rand_coord();
      idx = ENTRY_W'($urandom_range(0, 63));
      // Hitting a stored vertex exactly gives a zero distance.
      if (poly_count > 0 && $urandom_range(0, 3) == 0) begin
        v  = $urandom_range(0, poly_count - 1);
        px = poly_x[v];
        py = poly_y[v];
      end
      if (action == ACT_READ && poly_count > 0 && $urandom_range(0, 1) == 1)
        idx = ENTRY_W'($urandom_range(0, poly_count - 1));
      send_edit(action, px, py, idx);
    end
    idle_on = 1'b1;
  endtask

  task automatic test_drain_to_empty();
    while (poly_count > 0)
      send_edit(ACT_REMOVE, rand_coord(), rand_coord(), ENTRY_W'($urandom_range(0, 63)));
    send_edit(ACT_REMOVE, 1023, 0, 63);
    send_edit(ACT_MOVE, 0, 1023, 0);
    send_edit(ACT_READ, 0, 0, 0);
  endtask

  // Response side: a fresh stall is drawn after every accepted beat.
  initial begin
    rsp_bus.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (stall_left > 0) begin
        rsp_bus.ready = 1'b0;
        stall_left--;
      end else begin
        rsp_bus.ready = 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    edit_result_t exp_res;
    if (rst_n && rsp_bus.valid && rsp_bus.ready) begin
      stall_left = idle_on ? $urandom_range(0, 11) : 0;
      if (expected_results.size() == 0) begin
        $error("unexpected response beat: status %0d, index %0d", rsp_bus.status,
               rsp_bus.affected_index);
        failures++;
      end else begin
        exp_res = expected_results.pop_front();
        if (rsp_bus.status !== exp_res.status) begin
          $error("status: expected %0d, actual %0d", exp_res.status, rsp_bus.status);
          failures++;
        end
        if (rsp_bus.affected_index !== exp_res.affected) begin
          $error("affected_index: expected %0d, actual %0d", exp_res.affected,
                 rsp_bus.affected_index);
          failures++;
        end
        if (rsp_bus.point_count !== exp_res.count) begin
          $error("point_count: expected %0d, actual %0d", exp_res.count,
                 rsp_bus.point_count);
          failures++;
        end
        if (rsp_bus.x_out !== exp_res.x) begin
          $error("x_out: expected %0d, actual %0d", exp_res.x, rsp_bus.x_out);
          failures++;
        end
        if (rsp_bus.y_out !== exp_res.y) begin
          $error("y_out: expected %0d, actual %0d", exp_res.y, rsp_bus.y_out);
          failures++;
        end
      end
    end
  end

  initial begin
    rst_n               = 1'b0;
    req_bus.valid       = 1'b0;
    req_bus.action      = '0;
    req_bus.x_coord     = '0;
    req_bus.y_coord     = '0;
    req_bus.entry_index = '0;
    repeat (10) @(negedge clk);
    rst_n = 1'b1;

    test_directed();
    test_fill_to_full();
    test_random_mix(1350);
    test_drain_to_empty();

    wait_drained();
    repeat (200) @(posedge clk);
    if (failures == 0 && expected_results.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

### filelist.f
rtl/npe_pkg.sv
rtl/npe_if.sv
rtl/npe_ram.sv
rtl/npe_dist.sv
rtl/nearest_point_polygon_editor.sv
rtl/npe_checker.sv
tb/testbench.sv
